@@ design/i2c3w_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c3w_pkg
// Shared types and constants for the two-wire three-byte write master.
// ----------------------------------------------------------------------------
package i2c3w_pkg;

	// Configuration register indexes
	localparam logic CFG_HALF_PERIOD = 1'b0;
	localparam logic CFG_DEV_ADDR    = 1'b1;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;

	// Reset values of the configuration registers
	localparam logic [15:0] HALF_PERIOD_RESET = 16'd10;
	localparam logic [7:0]  DEV_ADDR_RESET    = 8'hA0;

	// Frame layout
	localparam logic [3:0] BITS_PER_BYTE   = 4'd8;
	localparam logic [1:0] BYTES_PER_WRITE = 2'd3;

	// Input item kinds
	localparam logic KIND_TICK    = 1'b0;
	localparam logic KIND_REQUEST = 1'b1;

	// Line phases, each held for one half period
	typedef enum logic [3:0] {
		PH_START_A = 4'd0,
		PH_START_B = 4'd1,
		PH_START_C = 4'd2,
		PH_BIT_HI  = 4'd3,
		PH_BIT_LO  = 4'd4,
		PH_ACK_HI  = 4'd5,
		PH_ACK_LO  = 4'd6,
		PH_STOP_A  = 4'd7,
		PH_STOP_B  = 4'd8,
		PH_STOP_C  = 4'd9
	} phase_t;

	// One input item
	typedef struct packed {
		logic       kind;
		logic [7:0] reg_addr;
		logic [7:0] data_byte;
		logic       sda_in;
	} item_t;

	// One result item
	typedef struct packed {
		logic [2:0] nack_mask;
		logic       done_res;
		logic       busy_res;
		logic       sda_out;
		logic       scl_out;
	} res_t;

endpackage

@@ design/i2c3w_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c3w_core
// Bus sequencer: phase state, bit/byte counters and shifter. Updates on each
// item it is handed and returns that item's result combinationally.
// ----------------------------------------------------------------------------
module i2c3w_core
	import i2c3w_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,        // item consumed this cycle
	input  item_t       item,
	input  logic [15:0] half_period,
	input  logic [7:0]  dev_addr,
	output res_t        res
);

	phase_t      phase_q, phase_d;
	logic [15:0] tick_count_q, tick_count_d;
	logic [7:0]  shift_q, shift_d;
	logic [7:0]  held_reg_q, held_reg_d;
	logic [7:0]  held_data_q, held_data_d;
	logic [3:0]  bit_index_q, bit_index_d;
	logic [1:0]  byte_index_q, byte_index_d;
	logic [2:0]  ack_flags_q, ack_flags_d;
	logic        active_q, active_d;

	logic [15:0] period;
	logic [15:0] tick_inc;
	logic [3:0]  bit_inc;
	logic [1:0]  byte_inc;
	logic        done;
	logic [1:0]  levels;     // bit1 clock, bit0 data

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_START_A;
			tick_count_q <= '0;
			shift_q      <= '0;
			held_reg_q   <= '0;
			held_data_q  <= '0;
			bit_index_q  <= '0;
			byte_index_q <= '0;
			ack_flags_q  <= '0;
			active_q     <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_d;
			tick_count_q <= tick_count_d;
			shift_q      <= shift_d;
			held_reg_q   <= held_reg_d;
			held_data_q  <= held_data_d;
			bit_index_q  <= bit_index_d;
			byte_index_q <= byte_index_d;
			ack_flags_q  <= ack_flags_d;
			active_q     <= active_d;
		end
	end

	assign period   = (half_period == '0) ? 16'd1 : half_period;
	assign tick_inc = tick_count_q + 16'd1;
	assign bit_inc  = bit_index_q + 4'd1;
	assign byte_inc = byte_index_q + 2'd1;

	// Next state
	always_comb begin
		phase_d      = phase_q;
		tick_count_d = tick_count_q;
		shift_d      = shift_q;
		held_reg_d   = held_reg_q;
		held_data_d  = held_data_q;
		bit_index_d  = bit_index_q;
		byte_index_d = byte_index_q;
		ack_flags_d  = ack_flags_q;
		active_d     = active_q;
		done         = 1'b0;

		if (item.kind == KIND_REQUEST) begin
			// new write only when idle; otherwise dropped
			if (!active_q) begin
				held_reg_d   = item.reg_addr;
				held_data_d  = item.data_byte;
				ack_flags_d  = '0;
				phase_d      = PH_START_A;
				tick_count_d = '0;
				bit_index_d  = '0;
				byte_index_d = '0;
				shift_d      = '0;
				active_d     = 1'b1;
			end
		end else if (active_q) begin
			tick_count_d = tick_inc;
			if (tick_inc >= period) begin
				tick_count_d = '0;
				unique case (phase_q)
					PH_START_A: phase_d = PH_START_B;
					PH_START_B: phase_d = PH_START_C;
					PH_START_C: begin
						shift_d      = dev_addr;
						bit_index_d  = '0;
						byte_index_d = '0;
						phase_d      = PH_BIT_HI;
					end
					PH_BIT_HI: phase_d = PH_BIT_LO;
					PH_BIT_LO: begin
						shift_d     = {shift_q[6:0], 1'b0};
						bit_index_d = bit_inc;
						phase_d     = (bit_inc >= BITS_PER_BYTE) ? PH_ACK_HI : PH_BIT_HI;
					end
					PH_ACK_HI: begin
						// data line high at end of ack clock: not acknowledged
						if (item.sda_in) begin
							unique case (byte_index_q)
								2'd0:    ack_flags_d = ack_flags_q | 3'b001;
								2'd1:    ack_flags_d = ack_flags_q | 3'b010;
								2'd2:    ack_flags_d = ack_flags_q | 3'b100;
								default: ack_flags_d = ack_flags_q;
							endcase
						end
						phase_d = PH_ACK_LO;
					end
					PH_ACK_LO: begin
						byte_index_d = byte_inc;
						if (byte_inc >= BYTES_PER_WRITE) begin
							phase_d = PH_STOP_A;
						end else begin
							shift_d     = (byte_inc == 2'd1) ? held_reg_q : held_data_q;
							bit_index_d = '0;
							phase_d     = PH_BIT_HI;
						end
					end
					PH_STOP_A: phase_d = PH_STOP_B;
					PH_STOP_B: phase_d = PH_STOP_C;
					PH_STOP_C: begin
						active_d = 1'b0;
						phase_d  = PH_START_A;
						done     = 1'b1;
					end
					default: begin
						active_d = 1'b0;
						phase_d  = PH_START_A;
					end
				endcase
			end
		end
	end

	// Line levels of the phase just entered
	always_comb begin
		if (!active_d) begin
			levels = 2'b11;
		end else begin
			unique case (phase_d)
				PH_START_A: levels = 2'b11;
				PH_START_B: levels = 2'b10;
				PH_START_C: levels = 2'b00;
				PH_BIT_HI:  levels = {1'b1, shift_d[7]};
				PH_BIT_LO:  levels = {1'b0, shift_d[7]};
				PH_ACK_HI:  levels = 2'b11;
				PH_ACK_LO:  levels = 2'b01;
				PH_STOP_A:  levels = 2'b00;
				PH_STOP_B:  levels = 2'b10;
				PH_STOP_C:  levels = 2'b11;
				default:    levels = 2'b11;
			endcase
		end
	end

	assign res.scl_out   = levels[1];
	assign res.sda_out   = levels[0];
	assign res.busy_res  = active_d;
	assign res.done_res  = done;
	assign res.nack_mask = ack_flags_d;

	// Idle sequencer always rests at the first start phase
	a_idle_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (phase_q == PH_START_A))
		else $error("idle with phase not at start");

	// Bit counter never passes one byte
	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_index_q <= BITS_PER_BYTE)
		else $error("bit index out of range");

	// While shifting bytes the byte counter stays within the frame
	a_byte_range: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && (phase_q == PH_BIT_HI || phase_q == PH_BIT_LO ||
		              phase_q == PH_ACK_HI || phase_q == PH_ACK_LO))
		|-> (byte_index_q < BYTES_PER_WRITE))
		else $error("byte index out of range during data phase");

	// Completion ends the write on that same step
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && done) |=> !active_q)
		else $error("still busy after done");

endmodule

@@ design/i2c_three_byte_write_master.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_three_byte_write_master
// Two-wire bus master performing one device/register/data byte write.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one item per transfer: tuser = 0 is a time tick,
//   tuser = 1 requests a write of tdata's register address and data byte.
//   Requests while a write is in progress are dropped. Each item yields
//   exactly one result on the master stream: the clock and data line levels,
//   busy, done and the three-bit not-acknowledged mask.
//   Each line phase lasts half_period_ticks ticks; set it and the device
//   address on the cfg port while the block is idle.
//   Each accepted item is held in the input register; the sequencer update
//   between it and the result register is combinational, and the result
//   register then takes its result. Throughput: one item per cycle while the master side takes results.
//   When the master side stalls, the result register holds and the input
//   register takes one more item, then s_tready drops until the result is
//   taken. Reset empties both registers, idles the sequencer with both lines
//   high and restores the period to 10 ticks and the device address to 0xA0.
// ----------------------------------------------------------------------------
module i2c_three_byte_write_master
	import i2c3w_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// slave stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [23:0]            s_tdata,   // [7:0] reg_addr, [15:8] data_byte,
	                                          // [16] sda_in, [23:17] zero
	input  logic                   s_tuser,   // [0] kind
	// master stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [7:0]             m_tdata,   // [0] scl_out, [1] sda_out, [2] busy_res,
	                                          // [3] done_res, [6:4] nack_mask, [7] zero
	// configuration
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [15:0] half_period_q;
	logic [7:0]  dev_addr_q;
	logic        valid_s1;
	item_t       item_s1;
	logic        m_valid_q;
	res_t        res_q;
	res_t        res;
	logic        advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
			dev_addr_q    <= DEV_ADDR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HALF_PERIOD: half_period_q <= cfg_data;
				CFG_DEV_ADDR:    dev_addr_q    <= cfg_data[7:0];
				default:         ;
			endcase
		end
	end

	// Handshake: s1 moves on whenever the result register is free or emptying
	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.kind      <= s_tuser;
			item_s1.reg_addr  <= s_tdata[7:0];
			item_s1.data_byte <= s_tdata[15:8];
			item_s1.sda_in    <= s_tdata[16];
		end
	end

	i2c3w_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.item        (item_s1),
		.half_period (half_period_q),
		.dev_addr    (dev_addr_q),
		.res         (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, res_q.nack_mask, res_q.done_res, res_q.busy_res,
	                   res_q.sda_out, res_q.scl_out};

endmodule
